// File: src/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package mi3_pkg;

  localparam int NUM_ENTRIES = 9;

  // sideband that travels with one divider lane
  typedef struct packed {
    logic neg;
    logic zero;
  } div_ctl_t;

endpackage
`default_nettype wire

// File: src/matrix_inverse_3x3_top.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_top
// 3x3 fixed-point matrix inverse by the adjugate, fully pipelined.
// ----------------------------------------------------------------------------
// One matrix is accepted every cycle while the pipe advances. The nine
// dividers resolve one quotient bit per stage; ahead of them sit two
// cofactor stages, two determinant stages and one magnitude stage. The whole
// pipe moves together: it holds only while a result is waiting and out_tready
// is low. A zero determinant sets out_tuser and zeroes every entry.
`default_nettype none
module matrix_inverse_3x3_top #(
  parameter int IN_WIDTH  = 16,
  parameter int OUT_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic                                     in_tvalid,
  output logic                                          in_tready,
  // e00 e01 e02 e10 e11 e12 e20 e21 e22, lowest bits first
  input  wire logic [((9*IN_WIDTH+7)/8)*8-1:0]          in_tdata,
  output logic                                          out_tvalid,
  input  wire logic                                     out_tready,
  // i00 i01 i02 i10 i11 i12 i20 i21 i22, lowest bits first
  output logic [((9*OUT_WIDTH+7)/8)*8-1:0]              out_tdata,
  // singular
  output logic                                          out_tuser
);

  localparam int IW  = IN_WIDTH;
  localparam int OW  = OUT_WIDTH;
  localparam int OTW = ((9*OW+7)/8)*8;
  localparam int CW  = 2*IW + 1;
  localparam int DTW = 3*IW + 3;
  localparam int SH  = (IW - 4) + OW/2;
  localparam int NW  = CW + SH;
  localparam int QB  = OW + 1;
  localparam int LAT = OW + 8;
  localparam int NE  = mi3_pkg::NUM_ENTRIES;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic signed [IW-1:0] e [NE];
  for (genvar k = 0; k < NE; k++) begin : g_unpack
    assign e[k] = in_tdata[k*IW +: IW];
  end

  logic signed [CW-1:0] cof  [NE];
  logic signed [IW-1:0] row0 [3];
  logic signed [CW-1:0] cofd [NE];
  logic signed [DTW-1:0] det;

  mi3_cofactor #(.IW(IW)) u_cof (
    .clk (clk), .en (en), .e (e), .cof (cof), .row0 (row0)
  );

  mi3_det #(.IW(IW)) u_det (
    .clk (clk), .en (en), .cof_i (cof), .row0 (row0), .cof_o (cofd), .det (det)
  );

  // magnitude stage: split signs off, shift numerators into place
  logic [NW-1:0]         n_r   [NE];
  mi3_pkg::div_ctl_t     ctl_r [NE];
  logic [DTW-1:0]        dmag_r;
  logic                  sing5_r;
  logic                  dzero;
  logic                  dneg;
  assign dzero = (det == '0);
  assign dneg  = det[DTW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NE; k++) begin
        n_r[k] <= NW'(cofd[k][CW-1] ? CW'(-cofd[k]) : CW'(cofd[k])) << SH;
        ctl_r[k].neg  <= cofd[k][CW-1] ^ dneg;
        ctl_r[k].zero <= dzero;
      end
      dmag_r  <= dneg ? DTW'(-det) : DTW'(det);
      sing5_r <= dzero;
    end
  end

  logic [OW-1:0] quo [NE];
  for (genvar k = 0; k < NE; k++) begin : g_div
    mi3_div #(.NW(NW), .DW(DTW), .OW(OW)) u_div (
      .clk (clk), .en (en), .num (n_r[k]), .den (dmag_r), .ctl (ctl_r[k]),
      .quo (quo[k])
    );
  end

  // singular flag and valid bits ride alongside the data
  logic sg_r [QB+2];
  logic v_r  [LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sg_r[0] <= sing5_r;
      for (int k = 1; k < QB + 2; k++) sg_r[k] <= sg_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_tvalid;
      for (int k = 1; k < LAT; k++) v_r[k] <= v_r[k-1];
    end
  end

  logic [9*OW-1:0] packed_q;
  for (genvar k = 0; k < NE; k++) begin : g_pack
    assign packed_q[k*OW +: OW] = quo[k];
  end

  assign out_tvalid = v_r[LAT-1];
  assign out_tdata  = OTW'(packed_q);
  assign out_tuser  = sg_r[QB+1];

  a_sing_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("singular result with nonzero entries");

  a_ready : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow pipe advance");

  a_reset : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
`default_nettype wire

// File: src/mi3_cofactor.sv
// ----------------------------------------------------------------------------
// mi3_cofactor
// Two stages: the eighteen 2x2 minor products, then the nine adjugate entries.
// Row 0 of the matrix is carried along for the determinant.
// ----------------------------------------------------------------------------
`default_nettype none
module mi3_cofactor #(
  parameter int IW = 16
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic signed [IW-1:0]   e   [9],
  output logic signed [2*IW:0]        cof [9],
  output logic signed [IW-1:0]        row0[3]
);

  localparam int CW = 2*IW + 1;
  localparam int PW = 2*IW;

  logic signed [2*IW-1:0] p_r [9];
  logic signed [2*IW-1:0] m_r [9];
  logic signed [IW-1:0]   r0a_r [3];
  logic signed [IW-1:0]   r0b_r [3];
  logic signed [CW-1:0]   cof_r [9];

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      always_ff @(posedge clk) begin
        if (en) begin
          p_r[i*3+j]   <= PW'(e[J1*3+I1]) * PW'(e[J2*3+I2]);
          m_r[i*3+j]   <= PW'(e[J1*3+I2]) * PW'(e[J2*3+I1]);
          cof_r[i*3+j] <= CW'(p_r[i*3+j]) - CW'(m_r[i*3+j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        r0a_r[k] <= e[k];
      end
      r0b_r <= r0a_r;
    end
  end

  assign cof  = cof_r;
  assign row0 = r0b_r;

endmodule
`default_nettype wire

// File: src/mi3_det.sv
// ----------------------------------------------------------------------------
// mi3_det
// Two stages: expansion products along row 0, then their sum. The cofactors
// are delayed to stay aligned with the determinant.
// ----------------------------------------------------------------------------
`default_nettype none
module mi3_det #(
  parameter int IW = 16
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [2*IW:0]    cof_i [9],
  input  wire logic signed [IW-1:0]    row0  [3],
  output logic signed [2*IW:0]         cof_o [9],
  output logic signed [3*IW+2:0]       det
);

  localparam int CW  = 2*IW + 1;
  localparam int PW  = CW + IW;
  localparam int DTW = PW + 2;

  logic signed [PW-1:0]  prod_r [3];
  logic signed [DTW-1:0] det_r;
  logic signed [CW-1:0]  ca_r [9];
  logic signed [CW-1:0]  cb_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        prod_r[j] <= PW'(cof_i[j*3]) * PW'(row0[j]);
      end
      det_r <= DTW'(prod_r[0]) + DTW'(prod_r[1]) + DTW'(prod_r[2]);
      ca_r  <= cof_i;
      cb_r  <= ca_r;
    end
  end

  assign cof_o = cb_r;
  assign det   = det_r;

endmodule
`default_nettype wire

// File: src/mi3_div.sv
// ----------------------------------------------------------------------------
// mi3_div
// Pipelined restoring divider, one quotient bit per stage, with overflow
// check up front and round-half-away plus saturation at the end.
// ----------------------------------------------------------------------------
`default_nettype none
module mi3_div #(
  parameter int NW = 61,
  parameter int DW = 51,
  parameter int OW = 32
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [NW-1:0]         num,
  input  wire logic [DW-1:0]         den,
  input  wire mi3_pkg::div_ctl_t     ctl,
  output logic [OW-1:0]              quo
);

  localparam int QB = OW + 1;
  localparam int XW = ((NW > DW + QB) ? NW : DW + QB) + 1;

  logic [XW-1:0]        r_r   [QB+1];
  logic [QB-1:0]        q_r   [QB+1];
  logic [DW-1:0]        d_r   [QB+1];
  logic                 ovf_r [QB+1];
  mi3_pkg::div_ctl_t    c_r   [QB+1];
  logic [OW-1:0]        quo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= XW'(num);
      q_r[0]   <= '0;
      d_r[0]   <= den;
      ovf_r[0] <= XW'(num) >= (XW'(den) << QB);
      c_r[0]   <= ctl;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int K = QB - 1 - s;
    logic [XW-1:0] trial;
    logic          ge;
    assign trial = XW'(d_r[s]) << K;
    assign ge    = r_r[s] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[s+1]   <= ge ? r_r[s] - trial : r_r[s];
        q_r[s+1]   <= q_r[s] | (QB'(ge) << K);
        d_r[s+1]   <= d_r[s];
        ovf_r[s+1] <= ovf_r[s];
        c_r[s+1]   <= c_r[s];
      end
    end
  end

  logic          rnd;
  logic [QB:0]   qq;
  logic [QB:0]   lim;
  logic [OW-1:0] res;

  always_comb begin
    rnd = {r_r[QB], 1'b0} >= {1'b0, XW'(d_r[QB])};
    qq  = {1'b0, q_r[QB]} + (QB+1)'(rnd);
    lim = (QB+1)'(1) << (OW - 1);
    if (c_r[QB].zero) begin
      res = '0;
    end else if (c_r[QB].neg) begin
      if (ovf_r[QB] || qq > lim) res = lim[OW-1:0];
      else                       res = OW'(-qq);
    end else begin
      if (ovf_r[QB] || qq >= lim) res = OW'(lim - (QB+1)'(1));
      else                        res = qq[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) quo_r <= res;
  end

  assign quo = quo_r;

endmodule
`default_nettype wire
